/* design/abcf_pkg.sv */
package abcf_pkg;

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;
	localparam int IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_BYPASS_MODE  = 3'd0;
	localparam logic [IDX_W-1:0] REG_RATE_NEGATE  = 3'd1;
	localparam logic [IDX_W-1:0] REG_ANGLE_OFFSET = 3'd2;
	localparam logic [IDX_W-1:0] REG_RATE_OFFSET  = 3'd3;
	localparam logic [IDX_W-1:0] REG_GAIN         = 3'd4;
	localparam logic [IDX_W-1:0] REG_ANGLE_SHIFT  = 3'd5;
	localparam logic [IDX_W-1:0] REG_BIAS_SHIFT   = 3'd6;

	localparam logic [4:0] ANGLE_SHIFT_RST = 5'd8;
	localparam logic [4:0] BIAS_SHIFT_RST  = 5'd12;

	typedef struct packed {
		logic               bypass_mode;
		logic               rate_negate;
		logic signed [15:0] angle_offset;
		logic signed [15:0] rate_offset;
		logic signed [31:0] rate_to_angle_gain;
		logic [4:0]         angle_corr_shift;
		logic [4:0]         bias_corr_shift;
	} cfg_t;

endpackage

/* design/abcf_regs.sv */
module abcf_regs
	import abcf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t            cfg_q;
	logic            wr_en;
	logic [IDX_W-1:0] idx;

	assign idx    = paddr[APB_AW-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bypass_mode        <= 1'b0;
			cfg_q.rate_negate        <= 1'b0;
			cfg_q.angle_offset       <= '0;
			cfg_q.rate_offset        <= '0;
			cfg_q.rate_to_angle_gain <= '0;
			cfg_q.angle_corr_shift   <= ANGLE_SHIFT_RST;
			cfg_q.bias_corr_shift    <= BIAS_SHIFT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_BYPASS_MODE:  cfg_q.bypass_mode        <= pwdata[0];
				REG_RATE_NEGATE:  cfg_q.rate_negate        <= pwdata[0];
				REG_ANGLE_OFFSET: cfg_q.angle_offset       <= pwdata[15:0];
				REG_RATE_OFFSET:  cfg_q.rate_offset        <= pwdata[15:0];
				REG_GAIN:         cfg_q.rate_to_angle_gain <= pwdata;
				REG_ANGLE_SHIFT:  cfg_q.angle_corr_shift   <= pwdata[4:0];
				REG_BIAS_SHIFT:   cfg_q.bias_corr_shift    <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BYPASS_MODE:  prdata = {31'd0, cfg_q.bypass_mode};
			REG_RATE_NEGATE:  prdata = {31'd0, cfg_q.rate_negate};
			REG_ANGLE_OFFSET: prdata = {16'd0, cfg_q.angle_offset};
			REG_RATE_OFFSET:  prdata = {16'd0, cfg_q.rate_offset};
			REG_GAIN:         prdata = cfg_q.rate_to_angle_gain;
			REG_ANGLE_SHIFT:  prdata = {27'd0, cfg_q.angle_corr_shift};
			REG_BIAS_SHIFT:   prdata = {27'd0, cfg_q.bias_corr_shift};
			default:          prdata = '0;
		endcase
	end

endmodule

/* design/abcf_biquad.sv */
module abcf_biquad
	import abcf_pkg::*;
#(
	parameter int FRAC_BITS = 10,
	parameter int COEF_A0   = 256,
	parameter int COEF_A1   = 512,
	parameter int COEF_A2   = 256,
	parameter int COEF_B1   = -1024,
	parameter int COEF_B2   = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic signed [31:0] x,
	output logic signed [31:0] y
);

	localparam logic signed [31:0] A0 = 32'(COEF_A0);
	localparam logic signed [31:0] A1 = 32'(COEF_A1);
	localparam logic signed [31:0] A2 = 32'(COEF_A2);
	localparam logic signed [31:0] B1 = 32'(COEF_B1);
	localparam logic signed [31:0] B2 = 32'(COEF_B2);

	logic signed [31:0] x1_q, x2_q, y1_q, y2_q;
	logic signed [63:0] p0, p1, p2, p3, p4;

	assign p0 = A0 * x;
	assign p1 = A1 * x1_q;
	assign p2 = A2 * x2_q;
	assign p3 = B1 * y1_q;
	assign p4 = B2 * y2_q;

	assign y = p0[FRAC_BITS+31:FRAC_BITS] + p1[FRAC_BITS+31:FRAC_BITS]
		+ p2[FRAC_BITS+31:FRAC_BITS] - p3[FRAC_BITS+31:FRAC_BITS]
		- p4[FRAC_BITS+31:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (step) begin
			x1_q <= x;
			x2_q <= x1_q;
			y1_q <= y;
			y2_q <= y1_q;
		end
	end

endmodule

/* design/abcf_comp.sv */
module abcf_comp
	import abcf_pkg::*;
#(
	parameter int FRAC_BITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  cfg_t               cfg,
	input  logic signed [31:0] x,
	input  logic signed [31:0] a,
	output logic signed [31:0] est
);

	logic signed [31:0] est_q, bias_q;
	logic signed [31:0] diff, est1, err1, est2, err2;
	logic signed [63:0] prod;

	assign diff = x - bias_q;
	assign prod = diff * cfg.rate_to_angle_gain;
	assign est1 = est_q + prod[FRAC_BITS+31:FRAC_BITS];
	assign err1 = est1 - a;
	assign est2 = est1 - (err1 >>> cfg.angle_corr_shift);
	assign err2 = est2 - a;
	assign est  = est2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q  <= '0;
			bias_q <= '0;
		end else if (step) begin
			est_q  <= est2;
			bias_q <= bias_q + (err2 >>> cfg.bias_corr_shift);
		end
	end

endmodule

/* design/attitude_biquad_complementary_filter_unit.sv */
// One-axis attitude filter: biquad on the gyro rate plus a
// complementary angle filter with gyro-bias tracking.
//
// Input channel: angle_sample, rate_sample with in_valid/in_ready. Output
// channel: angle_out, rate_out with out_valid/out_ready. One result beat
// per input beat, in order.
// Configuration goes through the APB port, registers at byte address 4*i;
// write them only while no beat is in flight.
//
// A beat accepted at an edge waits in the input stage, then moves to the
// output register. Throughput: one beat per cycle while out_ready holds,
// set by the combinational state update (six multipliers, estimate chain).
// The input stage keeps taking beats while the output register holds a
// result; a stalled receiver fills both stages, then in_ready drops.
// Reset clears the filter histories, angle and bias estimates and the
// valid flags; the registers return to their defaults.
module attitude_biquad_complementary_filter_unit
	import abcf_pkg::*;
#(
	parameter int FRAC_BITS = 10,
	parameter int COEF_A0   = 256,
	parameter int COEF_A1   = 512,
	parameter int COEF_A2   = 256,
	parameter int COEF_B1   = -1024,
	parameter int COEF_B2   = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] angle_sample,
	input  logic signed [15:0] rate_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] angle_out,
	output logic signed [15:0] rate_out
);

	cfg_t               cfg;
	logic               valid_s1;
	logic signed [15:0] ang_s1, rate_s1;
	logic signed [15:0] ang_c, rate_d, rate_c;
	logic               out_valid_q;
	logic signed [15:0] angle_q, rate_q;
	logic               adv, accept, step;
	logic signed [31:0] x_fp, a_fp, y, est;

	abcf_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	assign ang_c  = angle_sample - cfg.angle_offset;
	assign rate_d = rate_sample - cfg.rate_offset;
	assign rate_c = cfg.rate_negate ? -rate_d : rate_d;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign step     = adv && !cfg.bypass_mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ang_s1  <= ang_c;
			rate_s1 <= rate_c;
		end
	end

	assign x_fp = 32'(rate_s1) <<< FRAC_BITS;
	assign a_fp = 32'(ang_s1) <<< FRAC_BITS;

	abcf_biquad #(
		.FRAC_BITS(FRAC_BITS), .COEF_A0(COEF_A0), .COEF_A1(COEF_A1),
		.COEF_A2(COEF_A2), .COEF_B1(COEF_B1), .COEF_B2(COEF_B2)
	) u_biquad (
		.clk, .arst_n, .step, .x(x_fp), .y
	);

	abcf_comp #(
		.FRAC_BITS(FRAC_BITS)
	) u_comp (
		.clk, .arst_n, .step, .cfg, .x(x_fp), .a(a_fp), .est
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_q <= cfg.bypass_mode ? ang_s1 : est[FRAC_BITS+15:FRAC_BITS];
			rate_q  <= cfg.bypass_mode ? rate_s1 : y[FRAC_BITS+15:FRAC_BITS];
		end
	end

	assign out_valid = out_valid_q;
	assign angle_out = angle_q;
	assign rate_out  = rate_q;

	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("in_ready low while receiver is ready");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted beat not held in input stage");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(ang_s1) && $stable(rate_s1)))
		else $error("stalled input stage lost or changed its beat");

	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("advanced beat missing from output register");

endmodule
